@@ sv/asfet_pkg.sv @@
// ----------------------------------------------------------------------------
// asfet_pkg
// shared constants and codes for the allele site filter and error tally block
// ----------------------------------------------------------------------------
package asfet_pkg;

	// bases and matrix geometry
	localparam int NUM_BASES = 4;
	localparam int ROW_W     = 2;
	localparam int BASE_W    = 3;
	localparam int POS_W     = 32;

	// default widths of the top-level parameters
	localparam int DEF_ACC_WIDTH   = 48;
	localparam int DEF_COUNT_WIDTH = 16;

	// configuration registers
	localparam int ALT_COUNT_W = 16;
	localparam int FRAC_W      = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALT_COUNT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ALT_FRACTION = 2'd1;

	// q1.16 share
	localparam int SHARE_FRAC_W = 16;
	localparam int SHARE_W      = SHARE_FRAC_W + 1;
	localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(1) << SHARE_FRAC_W;

	// request and result codes
	localparam logic REQ_SITE    = 1'b0;
	localparam logic REQ_REPORT  = 1'b1;
	localparam logic KIND_SITE   = 1'b0;
	localparam logic KIND_ENTRY  = 1'b1;

endpackage

@@ sv/asfet_ram.sv @@
// ----------------------------------------------------------------------------
// asfet_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module asfet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                       wr_data,
	input  logic                                   rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                       rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/allele_site_filter_error_tally.sv @@
// ----------------------------------------------------------------------------
// allele_site_filter_error_tally
// classifies sites as homozygous or heterozygous, tallies homozygous counts
// into a 4x4 error matrix and reports the matrix with q1.16 row shares
// ----------------------------------------------------------------------------
// site record: registered at the input transfer; in S_SITE the matrix row
//   is written back (read-modify-write) or the result loaded, then S_IDLE
//   takes the next site; output stalls hold the site result and S_EMIT
// report: 16 results; per row S_RSUM takes the read data, S_RTOT the total,
//   per entry S_DSET, S_DIV (skipped: empty row, whole-row entry), S_EMIT loads
// reset: config registers to zero, matrix rows marked empty (read as zero)
// ----------------------------------------------------------------------------
module allele_site_filter_error_tally #(
	parameter int ACC_WIDTH   = asfet_pkg::DEF_ACC_WIDTH,
	parameter int COUNT_WIDTH = asfet_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [asfet_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [asfet_pkg::CFG_DATA_W-1:0]      cfg_data,

	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic [asfet_pkg::BASE_W-1:0]          site_base,
	input  logic [asfet_pkg::POS_W-1:0]           site_position,
	input  logic [COUNT_WIDTH-1:0]                total_depth,
	input  logic [COUNT_WIDTH-1:0]                count_a,
	input  logic [COUNT_WIDTH-1:0]                count_c,
	input  logic [COUNT_WIDTH-1:0]                count_g,
	input  logic [COUNT_WIDTH-1:0]                count_t,

	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  result_kind,
	output logic [asfet_pkg::POS_W-1:0]           out_position,
	output logic [asfet_pkg::ROW_W-1:0]           out_site_base,
	output logic [COUNT_WIDTH-1:0]                out_depth,
	output logic [COUNT_WIDTH-1:0]                out_a,
	output logic [COUNT_WIDTH-1:0]                out_c,
	output logic [COUNT_WIDTH-1:0]                out_g,
	output logic [COUNT_WIDTH-1:0]                out_t,
	output logic [asfet_pkg::ROW_W-1:0]           matrix_column,
	output logic [ACC_WIDTH-1:0]                  matrix_count,
	output logic [asfet_pkg::SHARE_W-1:0]         matrix_share,
	output logic                                  last_entry
);

	localparam int NB       = asfet_pkg::NUM_BASES;
	localparam int ROW_W    = asfet_pkg::ROW_W;
	localparam int ROWBITS  = NB * ACC_WIDTH;
	// alt sum needs two extra bits over a count
	localparam int ALT_W    = COUNT_WIDTH + 2;
	// alt * 65536 and fraction * depth both fit here
	localparam int CMP_W    = ALT_W + asfet_pkg::SHARE_FRAC_W;
	localparam int PROD_W   = asfet_pkg::FRAC_W + COUNT_WIDTH;
	localparam int PAIR_W   = ACC_WIDTH + 1;
	localparam int TOT_W    = ACC_WIDTH + 2;
	localparam int QW       = asfet_pkg::SHARE_FRAC_W;
	localparam int STEP_W   = $clog2(QW);
	localparam logic [ROW_W-1:0]  LAST_IDX  = ROW_W'(NB - 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QW - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SITE,
		S_RSUM,
		S_RTOT,
		S_DSET,
		S_DIV,
		S_EMIT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [asfet_pkg::ALT_COUNT_W-1:0] max_alt_count_q;
	logic [asfet_pkg::FRAC_W-1:0]      max_alt_fraction_q;

	// latched site record
	logic [asfet_pkg::BASE_W-1:0]      ref_q;
	logic [asfet_pkg::POS_W-1:0]       pos_q;
	logic [COUNT_WIDTH-1:0]            depth_q;
	logic [COUNT_WIDTH-1:0]            cnt_q [NB];

	// report walk and share divider
	logic [ROW_W-1:0]                  row_q;
	logic [ROW_W-1:0]                  col_q;
	logic [ACC_WIDTH-1:0]              row_data_q [NB];
	logic [PAIR_W-1:0]                 ab_q;
	logic [PAIR_W-1:0]                 cd_q;
	logic [TOT_W-1:0]                  total_q;
	logic [TOT_W-1:0]                  rem_q;
	logic [QW-1:0]                     quot_q;
	logic [STEP_W-1:0]                 step_q;
	logic [asfet_pkg::SHARE_W-1:0]     share_q;

	// matrix rows written since reset; an empty row reads as zero
	logic [NB-1:0]                     row_vld_q;
	logic                              rd_vld_q;

	// ram ports
	logic                              ram_wr_en;
	logic [ROW_W-1:0]                  ram_wr_addr;
	logic [ROWBITS-1:0]                ram_wr_data;
	logic                              ram_rd_en;
	logic [ROW_W-1:0]                  ram_rd_addr;
	logic [ROWBITS-1:0]                ram_rd_data;

	// output register
	logic                              out_valid_q;
	logic                              out_free;
	logic                              out_load;
	logic                              in_xfer;

	// site classification
	logic [ACC_WIDTH-1:0]              row_rd [NB];
	logic [ALT_W-1:0]                  sum_all;
	logic [ALT_W-1:0]                  alt;
	logic [PROD_W-1:0]                 frac_prod;
	logic                              is_homo;

	// divider step
	logic [TOT_W:0]                    rem_sh;
	logic                              q_bit;
	logic [TOT_W-1:0]                  rem_next;
	logic [QW-1:0]                     quot_next;
	logic [TOT_W-1:0]                  entry_ext;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	// output slot can take a new result this cycle
	assign out_free  = !out_valid_q || !out_stall;
	// a heterozygous site or a matrix entry enters the output register
	assign out_load  = out_free && ((state_q == S_EMIT)
		|| (state_q == S_SITE && !ref_q[asfet_pkg::BASE_W-1] && !is_homo));

	// ram read data, masked to zero for a row never written
	always_comb begin
		for (int j = 0; j < NB; j++) begin
			row_rd[j] = rd_vld_q ? ram_rd_data[j*ACC_WIDTH +: ACC_WIDTH] : '0;
		end
	end

	// alternate count: all four counts less the reference one
	always_comb begin
		sum_all = '0;
		for (int j = 0; j < NB; j++) begin
			sum_all = sum_all + ALT_W'(cnt_q[j]);
		end
		alt = sum_all - ALT_W'(cnt_q[ref_q[ROW_W-1:0]]);
	end

	assign frac_prod = max_alt_fraction_q * depth_q;
	assign is_homo   = (CMP_W'(alt) <= CMP_W'(max_alt_count_q))
		|| ((CMP_W'(alt) << asfet_pkg::SHARE_FRAC_W) <= CMP_W'(frac_prod));

	// row update: add the site counts into the reference row
	always_comb begin
		for (int j = 0; j < NB; j++) begin
			ram_wr_data[j*ACC_WIDTH +: ACC_WIDTH] = row_rd[j] + ACC_WIDTH'(cnt_q[j]);
		end
	end

	assign ram_wr_en   = (state_q == S_SITE) && !ref_q[asfet_pkg::BASE_W-1] && is_homo;
	assign ram_wr_addr = ref_q[ROW_W-1:0];

	// reads: the site row at transfer, row 0 at a report transfer, next row
	// once the last entry of a row is handed to the output register
	always_comb begin
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		if (in_xfer) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = (req_type == asfet_pkg::REQ_REPORT) ? '0 : site_base[ROW_W-1:0];
		end else if (state_q == S_EMIT && out_free && col_q == LAST_IDX
				&& row_q != LAST_IDX) begin
			ram_rd_en   = 1'b1;
			ram_rd_addr = row_q + ROW_W'(1);
		end
	end

	// restoring divider step for count * 65536 / row total
	assign entry_ext = TOT_W'(row_data_q[col_q]);
	assign rem_sh    = {rem_q, 1'b0};
	assign q_bit     = (rem_sh >= {1'b0, total_q});
	assign rem_next  = q_bit ? TOT_W'(rem_sh - {1'b0, total_q}) : rem_sh[TOT_W-1:0];
	assign quot_next = {quot_q[QW-2:0], q_bit};

	asfet_ram #(
		.WIDTH (ROWBITS),
		.DEPTH (NB)
	) u_matrix_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	// configuration writes, always ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_alt_count_q    <= '0;
			max_alt_fraction_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				asfet_pkg::CFG_MAX_ALT_COUNT: begin
					max_alt_count_q <= cfg_data[asfet_pkg::ALT_COUNT_W-1:0];
				end
				asfet_pkg::CFG_MAX_ALT_FRACTION: begin
					max_alt_fraction_q <= cfg_data[asfet_pkg::FRAC_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// main sequencer with the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			row_vld_q    <= '0;
			rd_vld_q     <= 1'b0;
			row_q        <= '0;
			col_q        <= '0;
			step_q       <= '0;
			result_kind  <= asfet_pkg::KIND_SITE;
			out_position <= '0;
			out_site_base <= '0;
			out_depth    <= '0;
			out_a        <= '0;
			out_c        <= '0;
			out_g        <= '0;
			out_t        <= '0;
			matrix_column <= '0;
			matrix_count <= '0;
			matrix_share <= '0;
			last_entry   <= 1'b0;
		end else begin
			// new result loaded, or the held one taken downstream
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (ram_rd_en) begin
				rd_vld_q <= row_vld_q[ram_rd_addr];
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (req_type == asfet_pkg::REQ_REPORT) begin
							row_q   <= '0;
							col_q   <= '0;
							state_q <= S_RSUM;
						end else begin
							ref_q    <= site_base;
							pos_q    <= site_position;
							depth_q  <= total_depth;
							cnt_q[0] <= count_a;
							cnt_q[1] <= count_c;
							cnt_q[2] <= count_g;
							cnt_q[3] <= count_t;
							state_q  <= S_SITE;
						end
					end
				end

				S_SITE: begin
					if (ref_q[asfet_pkg::BASE_W-1]) begin
						// unknown base: dropped
						state_q <= S_IDLE;
					end else if (is_homo) begin
						// row written back through the ram port this cycle
						row_vld_q[ref_q[ROW_W-1:0]] <= 1'b1;
						state_q <= S_IDLE;
					end else if (out_free) begin
						result_kind   <= asfet_pkg::KIND_SITE;
						out_position  <= pos_q;
						out_site_base <= ref_q[ROW_W-1:0];
						out_depth     <= depth_q;
						out_a         <= cnt_q[0];
						out_c         <= cnt_q[1];
						out_g         <= cnt_q[2];
						out_t         <= cnt_q[3];
						matrix_column <= '0;
						matrix_count  <= '0;
						matrix_share  <= '0;
						last_entry    <= 1'b0;
						state_q       <= S_IDLE;
					end
				end

				S_RSUM: begin
					for (int j = 0; j < NB; j++) begin
						row_data_q[j] <= row_rd[j];
					end
					ab_q    <= PAIR_W'(row_rd[0]) + PAIR_W'(row_rd[1]);
					cd_q    <= PAIR_W'(row_rd[2]) + PAIR_W'(row_rd[3]);
					state_q <= S_RTOT;
				end

				S_RTOT: begin
					total_q <= TOT_W'(ab_q) + TOT_W'(cd_q);
					state_q <= S_DSET;
				end

				S_DSET: begin
					if (total_q == '0) begin
						share_q <= '0;
						state_q <= S_EMIT;
					end else if (entry_ext == total_q) begin
						share_q <= asfet_pkg::SHARE_ONE;
						state_q <= S_EMIT;
					end else begin
						rem_q   <= entry_ext;
						quot_q  <= '0;
						step_q  <= '0;
						state_q <= S_DIV;
					end
				end

				S_DIV: begin
					rem_q  <= rem_next;
					quot_q <= quot_next;
					if (step_q == LAST_STEP) begin
						share_q <= {1'b0, quot_next};
						state_q <= S_EMIT;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end

				S_EMIT: begin
					if (out_free) begin
						result_kind   <= asfet_pkg::KIND_ENTRY;
						out_position  <= '0;
						out_site_base <= row_q;
						out_depth     <= '0;
						out_a         <= '0;
						out_c         <= '0;
						out_g         <= '0;
						out_t         <= '0;
						matrix_column <= col_q;
						matrix_count  <= row_data_q[col_q];
						matrix_share  <= share_q;
						last_entry    <= (row_q == LAST_IDX) && (col_q == LAST_IDX);
						if (col_q != LAST_IDX) begin
							col_q   <= col_q + ROW_W'(1);
							state_q <= S_DSET;
						end else if (row_q != LAST_IDX) begin
							// next row read was issued this cycle
							col_q   <= '0;
							row_q   <= row_q + ROW_W'(1);
							state_q <= S_RSUM;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a report entry never claims more than the whole row
	a_share_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_kind == asfet_pkg::KIND_ENTRY
		|-> matrix_share <= asfet_pkg::SHARE_ONE)
		else $error("matrix share above one");

	// end-of-report mark only on matrix entries
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && last_entry |-> result_kind == asfet_pkg::KIND_ENTRY)
		else $error("last entry on a site result");

	// divider remainder stays below the row total
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < total_q)
		else $error("share divider remainder out of range");

	// an accepted item blocks the next one from following straight behind it
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input accepted while busy");

	// matrix is never written during a report walk
	a_no_write_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> state_q == S_SITE && !$past(state_q == S_EMIT))
		else $error("matrix write outside a site update");

endmodule

@@ tb/tb_allele_site_filter_error_tally.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_allele_site_filter_error_tally
// streams site records and matrix report requests into the block, predicts
// the heterozygous sites passed out and the error matrix entries with their
// row shares, and checks every result transfer field by field
// ----------------------------------------------------------------------------
module tb_allele_site_filter_error_tally;
	import asfet_pkg::*;

	localparam int ACC_W = DEF_ACC_WIDTH;
	localparam int CNT_W = DEF_COUNT_WIDTH;

	// base codes on site_base
	localparam logic [BASE_W-1:0] BASE_A = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G = 3'd2;
	localparam logic [BASE_W-1:0] BASE_T = 3'd3;
	localparam logic [BASE_W-1:0] BASE_N = 3'd4;
	localparam logic [BASE_W-1:0] BASE_UNKNOWN_MAX = 3'd7;

	// register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	localparam int CYCLE_LIMIT  = 2500000;
	localparam int LONG_HOLD    = 400;
	localparam int SETTLE       = 8;
	localparam int PHASE_ITEMS  = 70;
	localparam int PHASES       = 6;

	typedef struct packed {
		logic                           req;
		logic [BASE_W-1:0]              base;
		logic [POS_W-1:0]               pos;
		logic [CNT_W-1:0]               depth;
		logic [NUM_BASES-1:0][CNT_W-1:0] cnt;   // [0]=A [1]=C [2]=G [3]=T
	} site_record_t;

	typedef struct packed {
		logic                           kind;
		logic [POS_W-1:0]               pos;
		logic [ROW_W-1:0]               row;
		logic [CNT_W-1:0]               depth;
		logic [NUM_BASES-1:0][CNT_W-1:0] cnt;
		logic [ROW_W-1:0]               column;
		logic [ACC_W-1:0]               count;
		logic [SHARE_W-1:0]             share;
		logic                           last;
	} call_record_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// configuration channel
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// input channel, payload fed from the record on offer
	logic         in_valid = 1'b0;
	logic         in_stall;
	site_record_t offered = '0;

	// result channel
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               result_kind;
	logic [POS_W-1:0]   out_position;
	logic [ROW_W-1:0]   out_site_base;
	logic [CNT_W-1:0]   out_depth;
	logic [CNT_W-1:0]   out_a;
	logic [CNT_W-1:0]   out_c;
	logic [CNT_W-1:0]   out_g;
	logic [CNT_W-1:0]   out_t;
	logic [ROW_W-1:0]   matrix_column;
	logic [ACC_W-1:0]   matrix_count;
	logic [SHARE_W-1:0] matrix_share;
	logic               last_entry;

	allele_site_filter_error_tally DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (offered.req),
		.site_base     (offered.base),
		.site_position (offered.pos),
		.total_depth   (offered.depth),
		.count_a       (offered.cnt[0]),
		.count_c       (offered.cnt[1]),
		.count_g       (offered.cnt[2]),
		.count_t       (offered.cnt[3]),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.out_position  (out_position),
		.out_site_base (out_site_base),
		.out_depth     (out_depth),
		.out_a         (out_a),
		.out_c         (out_c),
		.out_g         (out_g),
		.out_t         (out_t),
		.matrix_column (matrix_column),
		.matrix_count  (matrix_count),
		.matrix_share  (matrix_share),
		.last_entry    (last_entry)
	);

	// ------------------------------------------------------------------------
	// shadow of the block: thresholds and the 4x4 error matrix
	// ------------------------------------------------------------------------
	logic [ALT_COUNT_W-1:0] alt_limit = '0;
	logic [FRAC_W-1:0]      frac_limit = '0;
	logic [ACC_W-1:0]       tally [NUM_BASES][NUM_BASES];

	site_record_t record_queue [$];     // records waiting for the driver
	call_record_t awaited_calls [$];    // predicted result transfers, oldest first

	int  fail_count = 0;
	int  cycle_count = 0;
	int  sites_taken = 0;
	int  reports_taken = 0;
	int  hets_checked = 0;
	int  entries_checked = 0;
	bit  in_taken = 1'b0;               // input transfer at the last rising edge
	bit  idle_on = 1'b1;                // random gaps on both sides
	int  hold_requests = 0;
	int  hold_served = 0;

	initial begin
		for (int r = 0; r < NUM_BASES; r++)
			for (int c = 0; c < NUM_BASES; c++)
				tally[r][c] = '0;
	end

	// register write as the block sees it; spare indexes change nothing
	function automatic void load_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_MAX_ALT_COUNT:    alt_limit = data[ALT_COUNT_W-1:0];
			CFG_MAX_ALT_FRACTION: frac_limit = data[FRAC_W-1:0];
			default: ;
		endcase
	endfunction

	// floor(count * 2^16 / row total), zero for an empty row, one for a whole row
	function automatic logic [SHARE_W-1:0] row_share(logic [ACC_W-1:0] count,
			logic [ACC_W+1:0] total);
		logic [ACC_W+SHARE_FRAC_W+1:0] num;
		if (total == '0)
			return '0;
		if (total == (ACC_W+2)'(count))
			return SHARE_ONE;
		num = (ACC_W+SHARE_FRAC_W+2)'(count) << SHARE_FRAC_W;
		return SHARE_W'(num / total);
	endfunction

	// classify one accepted record: tally a homozygous site, pass out a
	// heterozygous one, or read out the whole matrix for a report
	function automatic void classify_and_tally(site_record_t rq);
		call_record_t     res;
		logic [CNT_W+1:0] alt;
		logic [63:0]      alt_scaled;
		logic [63:0]      frac_depth;
		logic [ACC_W+1:0] row_total;
		if (rq.req == REQ_REPORT) begin
			reports_taken++;
			for (int r = 0; r < NUM_BASES; r++) begin
				row_total = '0;
				for (int c = 0; c < NUM_BASES; c++)
					row_total += (ACC_W+2)'(tally[r][c]);
				for (int c = 0; c < NUM_BASES; c++) begin
					res = '0;
					res.kind = KIND_ENTRY;
					res.row = ROW_W'(r);
					res.column = ROW_W'(c);
					res.count = tally[r][c];
					res.share = row_share(tally[r][c], row_total);
					res.last = (r == NUM_BASES - 1) && (c == NUM_BASES - 1);
					awaited_calls.push_back(res);
				end
			end
			return;
		end
		sites_taken++;
		// N and the unused codes above it drop the site
		if (rq.base > BASE_T)
			return;
		alt = '0;
		for (int j = 0; j < NUM_BASES; j++)
			if (j != int'(rq.base))
				alt += (CNT_W+2)'(rq.cnt[j]);
		alt_scaled = 64'(alt) << SHARE_FRAC_W;
		frac_depth = 64'(frac_limit) * 64'(rq.depth);
		if (alt <= (CNT_W+2)'(alt_limit) || alt_scaled <= frac_depth) begin
			for (int j = 0; j < NUM_BASES; j++)
				tally[rq.base[ROW_W-1:0]][j] += ACC_W'(rq.cnt[j]);
			return;
		end
		res = '0;
		res.kind = KIND_SITE;
		res.pos = rq.pos;
		res.row = rq.base[ROW_W-1:0];
		res.depth = rq.depth;
		res.cnt = rq.cnt;
		awaited_calls.push_back(res);
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------------
	// monitor: input and result transfers at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		call_record_t got;
		call_record_t want;
		if (arst_n) begin
			cycle_count++;
			in_taken = in_valid && !in_stall;
			if (in_taken)
				classify_and_tally(offered);
			if (out_valid && !out_stall) begin
				got.kind = result_kind;
				got.pos = out_position;
				got.row = out_site_base;
				got.depth = out_depth;
				got.cnt[0] = out_a;
				got.cnt[1] = out_c;
				got.cnt[2] = out_g;
				got.cnt[3] = out_t;
				got.column = matrix_column;
				got.count = matrix_count;
				got.share = matrix_share;
				got.last = last_entry;
				if (awaited_calls.size() == 0) begin
					$error("result transfer with nothing expected (kind %0d)", got.kind);
					fail_count++;
				end else begin
					want = awaited_calls.pop_front();
					if (want.kind == KIND_SITE)
						hets_checked++;
					else
						entries_checked++;
					compare_field("result_kind", want.kind, got.kind);
					compare_field("out_position", want.pos, got.pos);
					compare_field("out_site_base", want.row, got.row);
					compare_field("out_depth", want.depth, got.depth);
					compare_field("out_a", want.cnt[0], got.cnt[0]);
					compare_field("out_c", want.cnt[1], got.cnt[1]);
					compare_field("out_g", want.cnt[2], got.cnt[2]);
					compare_field("out_t", want.cnt[3], got.cnt[3]);
					compare_field("matrix_column", want.column, got.column);
					compare_field("matrix_count", want.count, got.count);
					compare_field("matrix_share", want.share, got.share);
					compare_field("last_entry", want.last, got.last);
				end
			end
		end else begin
			in_taken = 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// driver: offers queued records at the falling edge, holds each one
	// steady until it transfers, then waits out a random gap
	// ------------------------------------------------------------------------
	int gap_left = 0;

	always @(negedge clk) begin : driver
		logic next_valid;
		next_valid = in_valid;
		if (in_valid && in_taken)
			next_valid = 1'b0;
		if (!next_valid && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (record_queue.size() != 0) begin
				offered = record_queue.pop_front();
				next_valid = 1'b1;
				gap_left = idle_on ? pick_gap() : 0;
			end
		end
		in_valid <= next_valid;
	end

	// ------------------------------------------------------------------------
	// receiver: random stalls plus a long hold when the sequence asks for one
	// ------------------------------------------------------------------------
	int hold_left = 0;
	int stall_left = 0;

	always @(negedge clk) begin : receiver
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 99) < 25) begin
			stall_left = pick_gap();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// sequence helpers
	// ------------------------------------------------------------------------
	task automatic write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		load_limit(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every record went in and every result came out, then let
	// a homozygous site still in flight settle
	task automatic drain();
		while (record_queue.size() != 0 || in_valid || awaited_calls.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic site_record_t site(logic [BASE_W-1:0] base, logic [POS_W-1:0] pos,
			logic [CNT_W-1:0] depth, logic [CNT_W-1:0] a, logic [CNT_W-1:0] c,
			logic [CNT_W-1:0] g, logic [CNT_W-1:0] t);
		site_record_t rq;
		rq.req = REQ_SITE;
		rq.base = base;
		rq.pos = pos;
		rq.depth = depth;
		rq.cnt[0] = a;
		rq.cnt[1] = c;
		rq.cnt[2] = g;
		rq.cnt[3] = t;
		return rq;
	endfunction

	// report request; the site fields are don't-care noise
	function automatic site_record_t report_req();
		site_record_t rq;
		rq = site(BASE_W'($urandom), $urandom, CNT_W'($urandom), CNT_W'($urandom),
			CNT_W'($urandom), CNT_W'($urandom), CNT_W'($urandom));
		rq.req = REQ_REPORT;
		return rq;
	endfunction

	// site records shaped to land on both sides of the thresholds
	function automatic site_record_t random_record();
		site_record_t rq;
		logic [CNT_W+1:0] sum;
		int style;
		int noisy_col;
		if ($urandom_range(0, 99) < 5)
			return report_req();
		rq.req = REQ_SITE;
		rq.pos = $urandom;
		rq.base = ($urandom_range(0, 99) < 8) ? BASE_W'($urandom_range(BASE_N, BASE_UNKNOWN_MAX))
			: BASE_W'($urandom_range(BASE_A, BASE_T));
		style = $urandom_range(0, 3);
		noisy_col = $urandom_range(0, NUM_BASES - 1);
		for (int j = 0; j < NUM_BASES; j++) begin
			case (style)
				0: rq.cnt[j] = CNT_W'($urandom_range(0, 3));
				1: rq.cnt[j] = CNT_W'($urandom_range(0, 200));
				2: rq.cnt[j] = CNT_W'($urandom);
				default: rq.cnt[j] = (j == noisy_col) ? CNT_W'($urandom)
					: CNT_W'($urandom_range(0, 20));
			endcase
		end
		// clean sites carry a deep reference count
		if (style != 2 && rq.base <= BASE_T)
			rq.cnt[rq.base[ROW_W-1:0]] = CNT_W'($urandom);
		sum = '0;
		for (int j = 0; j < NUM_BASES; j++)
			sum += (CNT_W+2)'(rq.cnt[j]);
		case ($urandom_range(0, 3))
			0: rq.depth = (sum > (CNT_W+2)'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
			1: rq.depth = CNT_W'($urandom);
			2: rq.depth = '0;
			default: rq.depth = CNT_W'($urandom_range(0, 30));
		endcase
		return rq;
	endfunction

	// ------------------------------------------------------------------------
	// timeout
	// ------------------------------------------------------------------------
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin : sequencer
		logic [ALT_COUNT_W-1:0] cnt_val;
		logic [FRAC_W-1:0]      frac_val;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// thresholds at reset: only alt zero counts as homozygous
		record_queue.push_back(report_req());                              // empty matrix
		record_queue.push_back(site(BASE_A, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		record_queue.push_back(site(BASE_A, 32'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0));
		record_queue.push_back(site(BASE_C, 32'd2, 16'd0, 16'd0, 16'd10, 16'd1, 16'd0));
		record_queue.push_back(site(BASE_N, 32'd3, 16'd9, 16'd0, 16'd0, 16'd0, 16'd0));
		record_queue.push_back(site(BASE_UNKNOWN_MAX, 32'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		record_queue.push_back(site(BASE_T, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		record_queue.push_back(report_req());                              // whole-row entry
		drain();

		// high extremes; upper data bit of the count register is dropped
		write_limit(CFG_MAX_ALT_COUNT, {1'b1, 16'hFFFF});
		write_limit(CFG_MAX_ALT_FRACTION, CFG_DATA_W'(SHARE_ONE));
		write_limit(CFG_SPARE_2, CFG_DATA_W'($urandom));
		write_limit(CFG_SPARE_3, CFG_DATA_W'($urandom));
		record_queue.push_back(site(BASE_G, 32'd10, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		record_queue.push_back(site(BASE_G, 32'd11, 16'd500, 16'd21845, 16'd21845,
			16'd100, 16'd21845));
		record_queue.push_back(site(BASE_T, 32'd12, 16'd0, 16'd0, 16'd300, 16'd0, 16'd0));
		record_queue.push_back(site(BASE_C, 32'd13, 16'hFFFF, 16'hFFFF, 16'd5, 16'd1, 16'd0));
		record_queue.push_back(report_req());                              // not cleared by a read
		drain();

		// half fraction, exact boundary on both sides
		write_limit(CFG_MAX_ALT_COUNT, 17'd0);
		write_limit(CFG_MAX_ALT_FRACTION, 17'd32768);
		record_queue.push_back(site(BASE_A, 32'd20, 16'd100, 16'd50, 16'd50, 16'd0, 16'd0));
		record_queue.push_back(site(BASE_A, 32'd21, 16'd100, 16'd49, 16'd51, 16'd0, 16'd0));
		record_queue.push_back(site(BASE_G, 32'd22, 16'd1, 16'd1, 16'd0, 16'd0, 16'd0));
		record_queue.push_back(report_req());
		drain();

		// count limit boundary
		write_limit(CFG_MAX_ALT_COUNT, 17'd3);
		write_limit(CFG_MAX_ALT_FRACTION, 17'd0);
		record_queue.push_back(site(BASE_C, 32'd30, 16'd3, 16'd1, 16'd7, 16'd1, 16'd1));
		record_queue.push_back(site(BASE_C, 32'd31, 16'd4, 16'd2, 16'd7, 16'd1, 16'd1));
		record_queue.push_back(report_req());
		drain();

		// random phases, each under its own thresholds
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					cnt_val = '0;
					frac_val = '0;
				end
				1: begin
					cnt_val = '1;
					frac_val = SHARE_ONE;
				end
				2: begin
					cnt_val = ALT_COUNT_W'($urandom_range(0, 20));
					frac_val = FRAC_W'($urandom_range(0, 65536));
				end
				3: begin
					cnt_val = ALT_COUNT_W'($urandom);
					frac_val = FRAC_W'(6554);
				end
				4: begin
					cnt_val = ALT_COUNT_W'(5);
					frac_val = FRAC_W'($urandom);
				end
				default: begin
					cnt_val = ALT_COUNT_W'($urandom_range(0, 300));
					frac_val = FRAC_W'($urandom);
				end
			endcase
			write_limit(CFG_MAX_ALT_COUNT, {1'($urandom), cnt_val});
			write_limit(CFG_MAX_ALT_FRACTION, frac_val);
			if (p == PHASES - 1)
				write_limit(CFG_SPARE_3, CFG_DATA_W'($urandom));
			// one stretch with no idling on either side
			idle_on = (p != 3);
			// long result hold while records keep coming, so the block backs up
			if (p == 1) begin
				@(posedge clk);
				hold_requests++;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// sender pause until the block has emptied out
				if (p == 2 && i == PHASE_ITEMS / 2)
					drain();
				record_queue.push_back(random_record());
			end
			drain();
		end
		idle_on = 1'b1;
		record_queue.push_back(report_req());
		drain();

		$display("tb: %0d site records, %0d reports; %0d heterozygous sites and %0d %s",
			sites_taken, reports_taken, hets_checked, entries_checked,
			"matrix entries checked");
		$display("tb: thresholds swept through both extremes and %0d random settings, %0d errors",
			PHASES - 2, fail_count);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
